// File: hdl/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

  localparam int unsigned PinW    = 14;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned EntryW  = 12;
  localparam int unsigned PinMax  = 9999;

  localparam logic [1:0] FUNC_DIGIT  = 2'd0;
  localparam logic [1:0] FUNC_ACCEPT = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  localparam logic [1:0] LM_LOCKED   = 2'd0;
  localparam logic [1:0] LM_UNLOCKED = 2'd1;
  localparam logic [1:0] LM_OPEN     = 2'd2;
  localparam logic [1:0] LM_BLOCKED  = 2'd3;

  localparam logic [1:0] LAST_FAIL   = 2'd2;
  localparam logic [3:0] MAX_DIGIT   = 4'd9;
  localparam logic [1:0] LAST_SLOT   = 2'd3;

  typedef enum logic [3:0] {
    MODE_LOCKED   = 4'b0001,
    MODE_UNLOCKED = 4'b0010,
    MODE_OPEN     = 4'b0100,
    MODE_BLOCKED  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [CodeW-1:0]  stored_code;
    logic [EntryW-1:0] entry_buf;
    logic [1:0]        entry_cnt;
    mode_t             mode;
    logic [1:0]        fails;
  } lock_state_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    c = LM_LOCKED;
    unique case (m)
      MODE_LOCKED:   c = LM_LOCKED;
      MODE_UNLOCKED: c = LM_UNLOCKED;
      MODE_OPEN:     c = LM_OPEN;
      MODE_BLOCKED:  c = LM_BLOCKED;
      default:       c = LM_LOCKED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kcl_pin_conv.sv
`default_nettype none

module kcl_pin_conv
  import kcl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [PinW-1:0]  cfg_wr_data,
  output logic                  load_valid,
  output logic [CodeW-1:0]      load_code
);

  logic [PinW-1:0] pin_c;
  logic [3:0]      th;
  logic [PinW-1:0] th_sub;
  logic [PinW-1:0] rem_full;

  logic [3:0]      th_r;
  logic [9:0]      rem_r;
  logic            pend_r;
  logic            pend_nxt;

  logic [3:0]      hu;
  logic [9:0]      hu_sub;
  logic [6:0]      rem2;
  logic [3:0]      te;
  logic [6:0]      te_sub;
  logic [6:0]      rem3;

  always_comb begin
    pin_c = (cfg_wr_data > PinW'(PinMax)) ? PinW'(PinMax) : cfg_wr_data;
    th     = 4'd0;
    th_sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (pin_c >= PinW'(k * 1000)) begin
        th     = 4'(k);
        th_sub = PinW'(k * 1000);
      end
    end
    rem_full = pin_c - th_sub;
  end

  assign pend_nxt = cfg_wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      th_r  <= th;
      rem_r <= rem_full[9:0];
    end
  end

  always_comb begin
    hu     = 4'd0;
    hu_sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_r >= 10'(k * 100)) begin
        hu     = 4'(k);
        hu_sub = 10'(k * 100);
      end
    end
    rem2   = 7'(rem_r - hu_sub);
    te     = 4'd0;
    te_sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        te     = 4'(k);
        te_sub = 7'(k * 10);
      end
    end
    rem3 = rem2 - te_sub;
  end

  assign load_valid = pend_r;
  assign load_code  = {th_r, hu, te, rem3[3:0]};

endmodule

`default_nettype wire

// File: hdl/kcl_next_state.sv
`default_nettype none

module kcl_next_state
  import kcl_pkg::*;
(
  input  wire lock_state_t cur,
  input  wire logic [1:0]  func,
  input  wire logic [3:0]  digit,
  output lock_state_t      nxt
);

  logic [CodeW-1:0] code;

  assign code = {cur.entry_buf, digit};

  always_comb begin
    nxt = cur;
    unique case (func)
      FUNC_DIGIT: begin
        if (cur.mode != MODE_OPEN && digit <= MAX_DIGIT) begin
          if (cur.entry_cnt != LAST_SLOT) begin
            nxt.entry_buf = {cur.entry_buf[EntryW-5:0], digit};
            nxt.entry_cnt = cur.entry_cnt + 2'd1;
          end else begin
            nxt.entry_buf = '0;
            nxt.entry_cnt = '0;
            unique case (cur.mode)
              MODE_LOCKED: begin
                if (code == cur.stored_code) begin
                  nxt.mode  = MODE_UNLOCKED;
                  nxt.fails = '0;
                end else if (cur.fails == LAST_FAIL) begin
                  nxt.mode  = MODE_BLOCKED;
                  nxt.fails = '0;
                end else begin
                  nxt.fails = cur.fails + 2'd1;
                end
              end
              MODE_UNLOCKED: begin
                nxt.stored_code = code;
                nxt.mode        = MODE_LOCKED;
                nxt.fails       = '0;
              end
              MODE_BLOCKED: begin
                nxt.stored_code = code;
                nxt.mode        = MODE_UNLOCKED;
                nxt.fails       = '0;
              end
              default: begin
                nxt.mode = cur.mode;
              end
            endcase
          end
        end
      end
      FUNC_ACCEPT: begin
        if (cur.mode == MODE_UNLOCKED) begin
          nxt.mode = MODE_OPEN;
        end
      end
      FUNC_CANCEL: begin
        nxt.entry_buf = '0;
        nxt.entry_cnt = '0;
        if (cur.mode == MODE_OPEN) begin
          nxt.mode  = MODE_LOCKED;
          nxt.fails = '0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/keypad_code_lock.sv
`default_nettype none

// Four-digit keypad code lock. Each input beat is one key press and yields
// exactly one result beat with the lock state after that press. A press is
// taken every cycle unless in_stall is high; it waits in the input register
// and its result beat is valid from the edge at which it moves into the
// result register, which waits while out_stall holds a result, and the lock
// state updates at that same edge. After reset the lock is Locked with PIN
// 0000. A write to cfg_wr_data restarts the lock; the new PIN, clamped to
// 9999, is converted to BCD via a register in kcl_pin_conv and then loaded.
module keypad_code_lock
  import kcl_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [PinW-1:0] cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_func,
  input  wire logic [3:0]      in_digit,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           out_lock_mode,
  output logic                 out_door_open,
  output logic [1:0]           out_failed_attempts,
  output logic [1:0]           out_digits_entered
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [1:0]       s1_func_r;
  logic [3:0]       s1_digit_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [1:0]       lock_mode_r;
  logic             door_open_r;
  logic [1:0]       fails_r;
  logic [1:0]       digits_r;

  lock_state_t      state_r;
  lock_state_t      state_nxt;
  lock_state_t      step_nxt;

  logic             in_accept;
  logic             s2_ready;
  logic             s2_fire;
  logic             load_valid;
  logic [CodeW-1:0] load_code;

  kcl_pin_conv u_pin_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .load_valid  (load_valid),
    .load_code   (load_code)
  );

  kcl_next_state u_next_state (
    .cur   (state_r),
    .func  (s1_func_r),
    .digit (s1_digit_r),
    .nxt   (step_nxt)
  );

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s2_fire   = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s2_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    state_nxt = state_r;
    if (s2_fire) begin
      state_nxt = step_nxt;
    end
    if (cfg_wr_en) begin
      state_nxt.entry_buf = '0;
      state_nxt.entry_cnt = '0;
      state_nxt.mode      = MODE_LOCKED;
      state_nxt.fails     = '0;
    end
    if (load_valid) begin
      state_nxt.stored_code = load_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{stored_code: '0, entry_buf: '0, entry_cnt: '0,
                       mode: MODE_LOCKED, fails: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= in_func;
      s1_digit_r <= in_digit;
    end
    if (s2_fire) begin
      lock_mode_r <= mode_code(step_nxt.mode);
      door_open_r <= (step_nxt.mode == MODE_OPEN);
      fails_r     <= (step_nxt.mode == MODE_LOCKED) ? step_nxt.fails : 2'd0;
      digits_r    <= step_nxt.entry_cnt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lock_mode       = lock_mode_r;
  assign out_door_open       = door_open_r;
  assign out_failed_attempts = fails_r;
  assign out_digits_entered  = digits_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with no item held");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> out_valid_r)
    else $error("processed beat did not reach the result register");

  a_fails_only_locked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fails != 2'd0 |-> state_r.mode == MODE_LOCKED)
    else $error("failure count held outside the locked mode");

  a_fails_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fails != 2'd3)
    else $error("failure count reached the blocking limit without blocking");

  a_door_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_door_open == (out_lock_mode == LM_OPEN))
    else $error("door flag disagrees with the lock mode");
`endif

endmodule

`default_nettype wire
